[rtl/bary2d_pkg.sv]
// Shared constants and types for the 2D barycentric weight pipeline.
`timescale 1ns / 1ps
`default_nettype none
package bary2d_pkg;

	localparam int COORD_BITS_DEF       = 24;
	localparam int COORD_FRAC_BITS_DEF  = 8;
	localparam int WEIGHT_BITS_DEF      = 21;
	localparam int WEIGHT_FRAC_BITS_DEF = 16;

	// Control that travels alongside the divider data.
	typedef struct packed {
		logic vld;
		logic dgn;
		logic neg_v;
		logic neg_w;
	} ctl_t;

endpackage
`default_nettype wire

[rtl/barycentric_weights_2d_top.sv]
// Top level of the 2D barycentric weight pipeline.
// The pipeline depth is set by the restoring divider, which resolves one quotient bit
// per stage. Throughput: one transfer per cycle on both sides while the skid entry is
// empty; an occupied skid entry stalls the input.
// Reset: arst_n clears all valid bits and the output skid entry; data is not reset.
`timescale 1ns / 1ps
`default_nettype none
module barycentric_weights_2d_top #(
	parameter int COORD_BITS       = bary2d_pkg::COORD_BITS_DEF,
	parameter int COORD_FRAC_BITS  = bary2d_pkg::COORD_FRAC_BITS_DEF,
	parameter int WEIGHT_BITS      = bary2d_pkg::WEIGHT_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = bary2d_pkg::WEIGHT_FRAC_BITS_DEF,
	localparam int IN_W  = ((8 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3 * WEIGHT_BITS + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output      logic             s_tready,
	// Fields from the lowest bit: px, py, ax, ay, bx, by_coord, cx, cy.
	input  wire logic [IN_W-1:0]  s_tdata,
	output      logic             m_tvalid,
	input  wire logic             m_tready,
	// Fields from the lowest bit: weight_u, weight_v, weight_w.
	output      logic [OUT_W-1:0] m_tdata,
	// Field: degenerate.
	output      logic             m_tuser
);

	// The coordinate scale cancels in every ratio, so COORD_FRAC_BITS only documents
	// the format. Differences of two coordinates need one extra bit, the products
	// twice that, and a cross product one more.
	localparam int CB  = COORD_BITS;
	localparam int D   = CB + 1;
	localparam int PW  = 2 * D;
	localparam int X   = PW + 1;
	localparam int N   = X + WEIGHT_FRAC_BITS;
	localparam int VW  = N + 1;
	localparam int UW  = N + 3;
	localparam int WB  = WEIGHT_BITS;
	localparam logic signed [UW-1:0] W_MAX = UW'((64'sd1 <<< (WB - 1)) - 64'sd1);
	localparam logic signed [UW-1:0] W_MIN = UW'(-(64'sd1 <<< (WB - 1)));
	localparam logic signed [UW-1:0] U_ONE = UW'(64'sd1 <<< WEIGHT_FRAC_BITS);
	localparam logic [COORD_FRAC_BITS:0] FRAC_UNUSED = '0;

	// The whole pipeline moves together. It stops only when the skid entry is
	// occupied, which is a registered condition, so the ready path stays short and
	// a new transfer is taken while a finished result waits in the output register.
	logic skid_vld_q;
	logic en;
	assign en       = !skid_vld_q;
	assign s_tready = en;

	// Stage 1: edge vectors and the offset of the point from the first corner.
	logic              vld_s1;
	logic signed [D-1:0] e0x_s1, e0y_s1, e1x_s1, e1y_s1, tx_s1, ty_s1;

	function automatic logic signed [D-1:0] diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
		diff = signed'({a[CB-1], a}) - signed'({b[CB-1], b});
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e0x_s1 <= diff(s_tdata[4*CB +: CB], s_tdata[2*CB +: CB]);
			e0y_s1 <= diff(s_tdata[5*CB +: CB], s_tdata[3*CB +: CB]);
			e1x_s1 <= diff(s_tdata[6*CB +: CB], s_tdata[2*CB +: CB]);
			e1y_s1 <= diff(s_tdata[7*CB +: CB], s_tdata[3*CB +: CB]);
			tx_s1  <= diff(s_tdata[0 +: CB],    s_tdata[2*CB +: CB]);
			ty_s1  <= diff(s_tdata[CB +: CB],   s_tdata[3*CB +: CB]);
		end
	end

	// Stage 2: the six products of the three cross products.
	logic                 vld_s2;
	logic signed [PW-1:0] pd0_s2, pd1_s2, pv0_s2, pv1_s2, pw0_s2, pw1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pd0_s2 <= e0x_s1 * e1y_s1;
			pd1_s2 <= e0y_s1 * e1x_s1;
			pv0_s2 <= tx_s1 * e1y_s1;
			pv1_s2 <= ty_s1 * e1x_s1;
			pw0_s2 <= e0x_s1 * ty_s1;
			pw1_s2 <= e0y_s1 * tx_s1;
		end
	end

	// Stage 3: the cross products. By the Lagrange identity these give the same
	// quotients as the Gram determinant and the dot products.
	logic                vld_s3;
	logic signed [X-1:0] den_s3, nv_s3, nw_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3 <= signed'({pd0_s2[PW-1], pd0_s2}) - signed'({pd1_s2[PW-1], pd1_s2});
			nv_s3  <= signed'({pv0_s2[PW-1], pv0_s2}) - signed'({pv1_s2[PW-1], pv1_s2});
			nw_s3  <= signed'({pw0_s2[PW-1], pw0_s2}) - signed'({pw1_s2[PW-1], pw1_s2});
		end
	end

	// Stage 4 (divider entry): magnitudes, quotient signs and the degenerate flag.
	// The dividend is the numerator magnitude scaled by the weight fraction.
	bary2d_pkg::ctl_t ctl_s   [0:N];
	logic [X-1:0]     den_s   [0:N];
	logic [N-1:0]     dvv_s   [0:N];
	logic [N-1:0]     dvw_s   [0:N];
	logic [X-1:0]     remv_s  [0:N];
	logic [X-1:0]     remw_s  [0:N];
	logic [N-1:0]     qv_s    [0:N];
	logic [N-1:0]     qw_s    [0:N];

	logic [X-1:0] mag_den, mag_nv, mag_nw;
	always_comb begin
		mag_den = den_s3[X-1] ? X'(-den_s3) : X'(den_s3);
		mag_nv  = nv_s3[X-1]  ? X'(-nv_s3)  : X'(nv_s3);
		mag_nw  = nw_s3[X-1]  ? X'(-nw_s3)  : X'(nw_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0].vld   <= vld_s3;
			ctl_s[0].dgn   <= (den_s3 == '0);
			ctl_s[0].neg_v <= nv_s3[X-1] ^ den_s3[X-1];
			ctl_s[0].neg_w <= nw_s3[X-1] ^ den_s3[X-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= mag_den;
			dvv_s[0]  <= {mag_nv, {WEIGHT_FRAC_BITS{1'b0}}};
			dvw_s[0]  <= {mag_nw, {WEIGHT_FRAC_BITS{1'b0}}};
			remv_s[0] <= '0;
			remw_s[0] <= '0;
			qv_s[0]   <= '0;
			qw_s[0]   <= '0;
		end
	end

	// Restoring division, one quotient bit per stage for both weights, most
	// significant dividend bit first. A zero divisor leaves garbage that the
	// degenerate flag masks later.
	for (genvar k = 0; k < N; k++) begin : g_div
		logic [X:0] trv, trw;
		logic       gev, gew;
		always_comb begin
			trv = {remv_s[k], dvv_s[k][N-1-k]};
			trw = {remw_s[k], dvw_s[k][N-1-k]};
			gev = (trv >= {1'b0, den_s[k]});
			gew = (trw >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1]  <= den_s[k];
				dvv_s[k+1]  <= dvv_s[k];
				dvw_s[k+1]  <= dvw_s[k];
				remv_s[k+1] <= gev ? X'(trv - {1'b0, den_s[k]}) : trv[X-1:0];
				remw_s[k+1] <= gew ? X'(trw - {1'b0, den_s[k]}) : trw[X-1:0];
				qv_s[k+1]   <= {qv_s[k][N-2:0], gev};
				qw_s[k+1]   <= {qw_s[k][N-2:0], gew};
			end
		end
	end

	// Stage 5: signed quotients and u = 1 - v - w from the unsaturated values.
	logic                 vld_s5, dgn_s5;
	logic signed [UW-1:0] u_s5, v_s5, w_s5;
	logic signed [VW-1:0] sv, sw;

	always_comb begin
		sv = ctl_s[N].neg_v ? -signed'({1'b0, qv_s[N]}) : signed'({1'b0, qv_s[N]});
		sw = ctl_s[N].neg_w ? -signed'({1'b0, qw_s[N]}) : signed'({1'b0, qw_s[N]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= ctl_s[N].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dgn_s5 <= ctl_s[N].dgn;
			v_s5   <= UW'(sv);
			w_s5   <= UW'(sw);
			u_s5   <= U_ONE - UW'(sv) - UW'(sw);
		end
	end

	// Saturation to the weight range; a degenerate triangle gives zero weights.
	function automatic logic [WB-1:0] sat(input logic signed [UW-1:0] x);
		logic [WB-1:0] r;
		if (x > W_MAX) begin
			r = W_MAX[WB-1:0];
		end else if (x < W_MIN) begin
			r = W_MIN[WB-1:0];
		end else begin
			r = x[WB-1:0];
		end
		sat = r;
	endfunction

	logic [OUT_W-1:0] res_data;
	always_comb begin
		res_data = '0;
		if (!dgn_s5) begin
			res_data[0 +: WB]      = sat(u_s5);
			res_data[WB +: WB]     = sat(v_s5);
			res_data[2*WB +: WB]   = sat(w_s5);
		end
	end

	// Output register with one skid entry behind it. While the output is stalled,
	// a result leaving the pipeline lands in the skid entry and halts the pipeline
	// on the next cycle; the skid drains first once the output transfer happens.
	logic [OUT_W-1:0] skid_data_q;
	logic             skid_dgn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid   <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			if (skid_vld_q) begin
				m_tvalid   <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				m_tvalid <= vld_s5;
			end
		end else if (en && vld_s5) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!m_tvalid || m_tready) begin
			if (skid_vld_q) begin
				m_tdata <= skid_data_q;
				m_tuser <= skid_dgn_q;
			end else begin
				m_tdata <= res_data;
				m_tuser <= dgn_s5;
			end
		end else if (en && vld_s5) begin
			skid_data_q <= res_data;
			skid_dgn_q  <= dgn_s5;
		end
	end

	// The skid entry only fills behind a stalled, occupied output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> m_tvalid)
		else $error("skid entry holds a result while the output register is empty");

	// A stalled output with a result leaving the pipeline must catch it in the skid.
	a_skid_catch: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && vld_s5 && en) |=> skid_vld_q)
		else $error("result dropped while the output was stalled");

	// A degenerate triangle carries zero weights.
	a_dgn_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("degenerate result with nonzero weights");

	// Input ready follows the skid entry; the coordinate fraction width never enters the arithmetic.
	a_frac_const: assert property (@(posedge clk) disable iff (!arst_n)
		FRAC_UNUSED == '0 |-> (s_tready == !skid_vld_q))
		else $error("input ready does not follow the skid entry");

endmodule
`default_nettype wire

[tb/tb_barycentric_weights_2d_top.sv]
// Self-checking testbench for the 2D barycentric weight pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tb_barycentric_weights_2d_top;

	localparam int CB    = bary2d_pkg::COORD_BITS_DEF;
	localparam int WB    = bary2d_pkg::WEIGHT_BITS_DEF;
	localparam int WF    = bary2d_pkg::WEIGHT_FRAC_BITS_DEF;
	localparam int IN_W  = ((8 * CB + 7) / 8) * 8;
	localparam int OUT_W = ((3 * WB + 7) / 8) * 8;
	localparam int LATENCY = 2 * CB + WF + 9;
	localparam int N_RANDOM = 1200;
	localparam longint CYCLE_LIMIT = 400000;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic signed [WB-1:0] weight_t;

	// One set of weights as the block should give it.
	typedef struct packed {
		weight_t wu;
		weight_t wv;
		weight_t ww;
		logic    dgn;
	} weights_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;

	logic [IN_W-1:0] pending_points[$];
	weights_t        expected_weights[$];
	int     errors = 0;
	int     n_sent = 0;
	int     n_checked = 0;
	int     n_degenerate = 0;
	int     n_saturated = 0;
	int     send_gap = 0;
	int     recv_gap = 0;
	longint cycle = 0;
	bit     stimulus_done = 1'b0;

	barycentric_weights_2d_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Clamps a wide signed value into the Q4.16 weight range.
	function automatic weight_t clamp_weight(logic signed [127:0] x);
		logic signed [127:0] hi, lo;
		hi = (128'sd1 <<< (WB - 1)) - 1;
		lo = -(128'sd1 <<< (WB - 1));
		if (x > hi) return hi[WB-1:0];
		if (x < lo) return lo[WB-1:0];
		return x[WB-1:0];
	endfunction

	// Truncating division of num * 2^WF by den; SystemVerilog signed division
	// already rounds toward zero, and 128 bits hold every operand exactly.
	function automatic logic signed [127:0] scaled_ratio(logic signed [127:0] num,
			logic signed [127:0] den);
		logic signed [127:0] shifted;
		shifted = num <<< WF;
		return shifted / den;
	endfunction

	// Works out the weights of the point in the triangle packed into one transfer.
	function automatic weights_t barycentric_weights(logic [IN_W-1:0] d);
		coord_t c[8];
		logic signed [127:0] e0x, e0y, e1x, e1y, tx, ty, det, nv, nw, qv, qw, qu;
		weights_t r;
		for (int i = 0; i < 8; i++) c[i] = d[i*CB +: CB];
		// Field order is px, py, ax, ay, bx, by_coord, cx, cy.
		e0x = 128'(c[4]) - 128'(c[2]);
		e0y = 128'(c[5]) - 128'(c[3]);
		e1x = 128'(c[6]) - 128'(c[2]);
		e1y = 128'(c[7]) - 128'(c[3]);
		tx  = 128'(c[0]) - 128'(c[2]);
		ty  = 128'(c[1]) - 128'(c[3]);
		det = e0x * e1y - e0y * e1x;
		r = '0;
		if (det == 0) begin
			r.dgn = 1'b1;
			return r;
		end
		nv = tx * e1y - ty * e1x;
		nw = e0x * ty - e0y * tx;
		qv = scaled_ratio(nv, det);
		qw = scaled_ratio(nw, det);
		// u is taken from the unclamped v and w, then clamped on its own.
		qu = (128'sd1 <<< WF) - qv - qw;
		r.wu = clamp_weight(qu);
		r.wv = clamp_weight(qv);
		r.ww = clamp_weight(qw);
		return r;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return coord_t'($urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}});
			1, 2: return coord_t'($signed($urandom_range(0, 2047)) - 1024);
			default: return coord_t'($urandom());
		endcase
	endfunction

	function automatic logic [IN_W-1:0] pack_item(coord_t px, coord_t py, coord_t ax,
			coord_t ay, coord_t bx, coord_t by_c, coord_t cx, coord_t cy);
		return {cy, cx, by_c, bx, ay, ax, py, px};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		coord_t mx, mn, ax, ay, bx, by_c, cx, cy, px, py, s;
		mx = {1'b0, {(CB-1){1'b1}}};
		mn = {1'b1, {(CB-1){1'b0}}};
		// A plain unit triangle with the point at each corner and inside.
		pending_points.push_back(pack_item(0, 0, 0, 0, 256, 0, 0, 256));
		pending_points.push_back(pack_item(256, 0, 0, 0, 256, 0, 0, 256));
		pending_points.push_back(pack_item(0, 256, 0, 0, 256, 0, 0, 256));
		pending_points.push_back(pack_item(85, 85, 0, 0, 256, 0, 0, 256));
		// Reversed winding gives a negative determinant.
		pending_points.push_back(pack_item(60, 90, 0, 0, 0, 256, 256, 0));
		// Degenerate triangles: coincident corners and collinear corners.
		pending_points.push_back(pack_item(5, 7, 3, 3, 3, 3, 3, 3));
		pending_points.push_back(pack_item(mx, mn, 0, 0, 100, 100, -200, -200));
		pending_points.push_back(pack_item(mn, mn, mn, mn, mn, mn, mn, mn));
		// Tiny triangle with a far point: v and w saturate, and u does too in the first two.
		pending_points.push_back(pack_item(mx, mx, 0, 0, 1, 0, 0, 1));
		pending_points.push_back(pack_item(mn, mn, 0, 0, 1, 0, 0, 1));
		pending_points.push_back(pack_item(mn, mx, 0, 0, 1, 0, 0, 1));
		// Full-range corners and points.
		pending_points.push_back(pack_item(mx, mx, mn, mn, mx, mn, mn, mx));
		pending_points.push_back(pack_item(mn, mn, mn, mn, mx, mn, mn, mx));
		pending_points.push_back(pack_item(mx, mn, mx, mx, mn, mx, mx, mn));
		pending_points.push_back(pack_item(-1, -1, mn, mx, mx, mn, -1, 0));
		pending_points.push_back(pack_item(0, 0, mx, 0, 0, mx, mn, mn));
		// Weights of thirds, with truncation of a non-exact third.
		pending_points.push_back(pack_item(1, 1, 0, 0, 3, 0, 0, 3));
		pending_points.push_back(pack_item(-1, -1, 0, 0, 3, 0, 0, 3));
		for (int i = 0; i < N_RANDOM; i++) begin
			ax = rand_coord();
			ay = rand_coord();
			case ($urandom_range(0, 9))
				0: begin
					// Collinear corners, scaled copies of one direction.
					s = coord_t'($signed($urandom_range(0, 63)) - 32);
					bx = ax + s;
					by_c = ay + coord_t'(s * 2);
					cx = ax - coord_t'(s * 3);
					cy = ay - coord_t'(s * 6);
				end
				1, 2, 3: begin
					// Small triangle near A; the point may land nearby or anywhere.
					bx = ax + coord_t'($urandom_range(1, 4000));
					by_c = ay + coord_t'($signed($urandom_range(0, 4000)) - 2000);
					cx = ax + coord_t'($signed($urandom_range(0, 4000)) - 2000);
					cy = ay + coord_t'($urandom_range(1, 4000));
				end
				default: begin
					bx = rand_coord();
					by_c = rand_coord();
					cx = rand_coord();
					cy = rand_coord();
				end
			endcase
			if ($urandom_range(0, 1)) begin
				px = ax + coord_t'($signed($urandom_range(0, 8000)) - 4000);
				py = ay + coord_t'($signed($urandom_range(0, 8000)) - 4000);
			end else begin
				px = rand_coord();
				py = rand_coord();
			end
			pending_points.push_back(pack_item(px, py, ax, ay, bx, by_c, cx, cy));
		end
	end

	// Driver: presents queued items, with random gaps between transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				expected_weights.push_back(barycentric_weights(s_tdata));
				n_sent <= n_sent + 1;
			end
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_points.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_points.pop_front();
				send_gap <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
				stimulus_done <= 1'b1;
			end
		end
	end

	// Monitor: compares each output transfer with the oldest expected set of weights.
	always @(posedge clk or negedge arst_n) begin
		weights_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.wu = m_tdata[0 +: WB];
				got.wv = m_tdata[WB +: WB];
				got.ww = m_tdata[2*WB +: WB];
				got.dgn = m_tuser;
				if (expected_weights.size() == 0) begin
					$error("output transfer with nothing expected");
					errors++;
				end else begin
					want = expected_weights.pop_front();
					n_checked++;
					if (want.dgn) n_degenerate++;
					if (!want.dgn && (want.wv == weight_t'({1'b0, {(WB-1){1'b1}}}) ||
							want.wv == weight_t'({1'b1, {(WB-1){1'b0}}})))
						n_saturated++;
					if (got.wu !== want.wu) begin
						$error("weight_u expected %0d got %0d", want.wu, got.wu);
						errors++;
					end
					if (got.wv !== want.wv) begin
						$error("weight_v expected %0d got %0d", want.wv, got.wv);
						errors++;
					end
					if (got.ww !== want.ww) begin
						$error("weight_w expected %0d got %0d", want.ww, got.ww);
						errors++;
					end
					if (got.dgn !== want.dgn) begin
						$error("degenerate expected %0b got %0b", want.dgn, got.dgn);
						errors++;
					end
				end
			end
			// The receiver stalls in random stretches too.
			if (recv_gap > 0) begin
				m_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				m_tready <= 1'b1;
				recv_gap <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (!(stimulus_done && expected_weights.size() == 0)) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		$display("%0d triangles sent, %0d results checked", n_sent, n_checked);
		$display("%0d were degenerate, %0d had v clamped", n_degenerate, n_saturated);
		if (errors == 0 && expected_weights.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
